FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// plain property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/xbr_pkg.sv
package xbr_pkg;

	// word and field widths
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BOUND_W = 31;
	localparam int unsigned CNT_W   = $clog2(WORD_W);

	// seeding recurrence
	localparam int unsigned SEED_WORDS = 4;
	localparam int unsigned IDX_W      = $clog2(SEED_WORDS);
	localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;

	// full-range numerator for the scaling factor
	localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

	// generator state after reset
	localparam logic [WORD_W-1:0] GEN_RESET_0 = 32'd123456789;
	localparam logic [WORD_W-1:0] GEN_RESET_1 = 32'd362436069;
	localparam logic [WORD_W-1:0] GEN_RESET_2 = 32'd521288629;
	localparam logic [WORD_W-1:0] GEN_RESET_3 = 32'd88675123;

	// request kinds
	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_DIV1,
		ST_MUL,
		ST_GEN,
		ST_DIV2,
		ST_DONE
	} state_t;

	// status of a bit-serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} ser_stat_t;

endpackage

FILE: hw/rtl/xbr_div_serial.sv
module xbr_div_serial (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [xbr_pkg::WORD_W-1:0] dividend,
	input  logic [xbr_pkg::WORD_W-1:0] divisor,
	output logic [xbr_pkg::WORD_W-1:0] quotient,
	output xbr_pkg::ser_stat_t         stat
);
	import xbr_pkg::*;

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic              ge;

	// one restoring step: bring down the next dividend bit and try to subtract
	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// sequencing: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/xbr_mul_serial.sv
module xbr_mul_serial (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [xbr_pkg::WORD_W-1:0] mul_a,
	input  logic [xbr_pkg::WORD_W-1:0] mul_b,
	output logic [xbr_pkg::WORD_W-1:0] product,
	output xbr_pkg::ser_stat_t         stat
);
	import xbr_pkg::*;

	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	// sequencing: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add, keeping only the low word of the product
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= mul_a;
			b_q   <= mul_b;
		end else if (busy_q) begin
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/xoroshiro_bounded_random.sv
// Bounded uniform random numbers from a xoroshiro128+ generator (rotations 55, 14, 36)
// whose 128-bit state sits in four 32-bit words. A draw transaction with bound m of 2 or
// more returns a value in 0 .. m-1, unbiased by rejection; a bound of 0 or 1 returns 0 and
// leaves the generator alone. A seed transaction refills the state from a 32-bit seed and
// returns 0. One request is worked at a time; a new one is taken while the previous result
// still waits at the output. The work is done by the bit-serial divider and multiplier, which
// resolve one bit per cycle and raise a done strobe together with the last bit. A draw
// runs the scaling divide, the rejection limit multiply, one or more generator steps and
// the final divide; a seed runs four multiplies; a trivial bound goes to the output.
`include "assert_macros.svh"

module xoroshiro_bounded_random (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [30:0] bound, [62:31] seed_value, [63] zero
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [30:0] value, [31] zero
);
	import xbr_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [WORD_W-1:0]  g_q [SEED_WORDS];
	logic [IDX_W-1:0]   idx_q;
	logic [BOUND_W-1:0] m_q;
	logic [WORD_W-1:0]  scaling_q;
	logic [WORD_W-1:0]  past_q;
	logic [BOUND_W-1:0] res_q;
	logic               out_valid_q;
	logic [BOUND_W-1:0] out_value_q;

	logic [BOUND_W-1:0] in_bound;
	logic [WORD_W-1:0]  in_seed;
	logic               in_req;

	logic [WORD_W-1:0]  mix_in;
	logic [WORD_W-1:0]  new_seed;
	logic [WORD_W-1:0]  mix_new;

	logic [2*WORD_W-1:0] s0;
	logic [2*WORD_W-1:0] s1;
	logic [2*WORD_W-1:0] sx;
	logic [2*WORD_W-1:0] n0;
	logic [2*WORD_W-1:0] n1;
	logic [WORD_W-1:0]   gen_out;
	logic                gen_hit;
	logic                out_load;

	logic              div_start;
	logic [WORD_W-1:0] div_dvd;
	logic [WORD_W-1:0] div_dvs;
	logic [WORD_W-1:0] div_quo;
	ser_stat_t         div_st;

	logic              mul_start;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_b;
	logic [WORD_W-1:0] mul_res;
	ser_stat_t         mul_st;

	localparam logic [IDX_W-1:0] SEED_LAST = IDX_W'(SEED_WORDS - 1);

	// input fields
	assign in_bound = s_tdata[BOUND_W-1:0];
	assign in_seed  = s_tdata[BOUND_W+WORD_W-1:BOUND_W];
	assign in_req   = s_tuser;

	// seed recurrence: mix, multiply serially, then add the word number
	assign mix_in   = in_seed ^ (in_seed >> 30);
	assign new_seed = mul_res + WORD_W'(idx_q) + 1'b1;
	assign mix_new  = new_seed ^ (new_seed >> 30);

	// one generator step: output is the low word of s0 + s1
	assign s0      = {g_q[1], g_q[0]};
	assign s1      = {g_q[3], g_q[2]};
	assign gen_out = g_q[0] + g_q[2];
	assign sx      = s1 ^ s0;
	assign n0      = {s0[8:0], s0[63:9]} ^ sx ^ (sx << 14);
	assign n1      = {sx[27:0], sx[63:28]};
	assign gen_hit = (gen_out < past_q);

	// serial arithmetic units
	xbr_div_serial u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_st)
	);

	xbr_mul_serial u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.product (mul_res),
		.stat    (mul_st)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// next state and unit launches
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = WORD_MAX;
		div_dvs   = {1'b0, in_bound};
		mul_start = 1'b0;
		mul_a     = mix_in;
		mul_b     = SEED_MULT;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_req == REQ_SEED) begin
						mul_start = 1'b1;
						state_d   = ST_SEED;
					end else if (in_bound > BOUND_W'(1)) begin
						div_start = 1'b1;
						state_d   = ST_DIV1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SEED: begin
				if (mul_st.done) begin
					if (idx_q == SEED_LAST) begin
						state_d = ST_DONE;
					end else begin
						mul_start = 1'b1;
						mul_a     = mix_new;
					end
				end
			end
			ST_DIV1: begin
				if (div_st.done) begin
					mul_start = 1'b1;
					mul_a     = div_quo;
					mul_b     = {1'b0, m_q};
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_st.done) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				if (gen_hit) begin
					div_start = 1'b1;
					div_dvd   = gen_out;
					div_dvs   = scaling_q;
					state_d   = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (div_st.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// generator words and seed word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q[0] <= GEN_RESET_0;
			g_q[1] <= GEN_RESET_1;
			g_q[2] <= GEN_RESET_2;
			g_q[3] <= GEN_RESET_3;
			idx_q  <= '0;
		end else begin
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_SEED && mul_st.done) begin
				g_q[idx_q] <= new_seed;
				idx_q      <= idx_q + 1'b1;
			end else if (state_q == ST_GEN) begin
				g_q[0] <= n0[WORD_W-1:0];
				g_q[1] <= n0[2*WORD_W-1:WORD_W];
				g_q[2] <= n1[WORD_W-1:0];
				g_q[3] <= n1[2*WORD_W-1:WORD_W];
			end
		end
	end

	// draw operands and result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			m_q   <= in_bound;
			res_q <= '0;
		end
		if (state_q == ST_DIV1 && div_st.done) begin
			scaling_q <= div_quo;
		end
		if (state_q == ST_MUL && mul_st.done) begin
			past_q <= mul_res;
		end
		if (state_q == ST_DIV2 && div_st.done) begin
			res_q <= div_quo[BOUND_W-1:0];
		end
		if (out_load) begin
			out_value_q <= res_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_value_q};

	// checks
	`ASSERT_IMPL(a_div_done_owned, clk, arst_n, div_st.done, (state_q == ST_DIV1 || state_q == ST_DIV2))
	`ASSERT_IMPL(a_mul_done_owned, clk, arst_n, mul_st.done, (state_q == ST_MUL || state_q == ST_SEED))
	`ASSERT_IMPL(a_draw_in_range, clk, arst_n, (state_q == ST_DIV2 && div_st.done), (div_quo < {1'b0, m_q}))
	`ASSERT_IMPL(a_idle_units_free, clk, arst_n, s_tready, (!div_st.busy && !mul_st.busy))

endmodule

FILE: tb/xoroshiro_bounded_random_checker.sv
`timescale 1ns / 100ps

module xoroshiro_bounded_random_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // [30:0] bound, [62:31] seed_value, [63] zero
	input  logic        s_tuser,   // [0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [30:0] value, [31] zero
	output int          mismatches,
	output int          pending
);
	import xbr_pkg::*;

	localparam int unsigned ROT_A   = 55;
	localparam int unsigned SHIFT_B = 14;
	localparam int unsigned ROT_C   = 36;
	localparam int unsigned REPORT_MAX = 10;

	// shadow copy of the generator words
	logic [WORD_W-1:0] gen_w [SEED_WORDS];
	// results still owed by the block (draws and seeds), oldest first
	logic [BOUND_W-1:0] draw_q [$];
	int n_err = 0;

	assign mismatches = n_err;

	// one xoroshiro128+ step, returns the low word of s0 + s1
	function automatic logic [31:0] gen_advance();
		logic [63:0] lane0;
		logic [63:0] lane1;
		logic [63:0] nxt0;
		logic [63:0] nxt1;
		logic [31:0] sum;
		lane0 = {gen_w[1], gen_w[0]};
		lane1 = {gen_w[3], gen_w[2]};
		sum   = lane0[31:0] + lane1[31:0];
		lane1 = lane1 ^ lane0;
		nxt0  = ((lane0 << ROT_A) | (lane0 >> (64 - ROT_A))) ^ lane1 ^ (lane1 << SHIFT_B);
		nxt1  = (lane1 << ROT_C) | (lane1 >> (64 - ROT_C));
		gen_w[0] = nxt0[31:0];
		gen_w[1] = nxt0[63:32];
		gen_w[2] = nxt1[31:0];
		gen_w[3] = nxt1[63:32];
		return sum;
	endfunction

	// expected value of one request, updates the shadow state
	function automatic logic [BOUND_W-1:0] predict_value(input logic kind,
			input logic [BOUND_W-1:0] bnd, input logic [WORD_W-1:0] seed);
		logic [31:0] s;
		logic [31:0] m;
		logic [31:0] scaling;
		logic [31:0] past;
		logic [31:0] r;
		logic [31:0] q;
		if (kind == REQ_SEED) begin
			s = seed;
			for (int i = 1; i <= SEED_WORDS; i++) begin
				s = SEED_MULT * (s ^ (s >> 30)) + 32'(i);
				gen_w[i-1] = s;
			end
			return '0;
		end
		m = {1'b0, bnd};
		if (m <= 32'd1)
			return '0;
		scaling = WORD_MAX / m;
		past    = scaling * m;
		// rejection loop, keeps stepping until the draw is below the limit
		do begin
			r = gen_advance();
		end while (r >= past);
		q = r / scaling;
		return q[BOUND_W-1:0];
	endfunction

	// compare results against the oldest expectation, then queue new predictions
	always @(posedge clk or negedge arst_n) begin : track
		logic [BOUND_W-1:0] want;
		if (!arst_n) begin
			gen_w[0] = GEN_RESET_0;
			gen_w[1] = GEN_RESET_1;
			gen_w[2] = GEN_RESET_2;
			gen_w[3] = GEN_RESET_3;
			draw_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (draw_q.size() == 0) begin
					if (n_err < REPORT_MAX)
						$display("unexpected result transaction: tdata %h", m_tdata);
					n_err++;
				end else begin
					want = draw_q.pop_front();
					if (m_tdata !== {1'b0, want}) begin
						if (n_err < REPORT_MAX)
							$display("value mismatch: expected %0d, got %0d (tdata %h)",
								want, m_tdata[BOUND_W-1:0], m_tdata);
						n_err++;
					end
				end
			end
			if (s_tvalid && s_tready)
				draw_q.push_back(predict_value(s_tuser, s_tdata[30:0], s_tdata[62:31]));
			pending <= draw_q.size();
		end
	end

endmodule

FILE: tb/xoroshiro_bounded_random_tb.sv
`timescale 1ns / 100ps

module xoroshiro_bounded_random_tb;
	import xbr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_ITEMS = 1030;
	localparam int unsigned HOLD_AFTER = 150;
	localparam int unsigned HOLD_CYCLES = 1000;
	localparam int unsigned DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [30:0] bound, [62:31] seed_value, [63] zero
	logic        s_tuser = 1'b0; // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [30:0] value, [31] zero

	int mismatches;
	int pending;
	int unsigned n_sent = 0;
	int unsigned cycle_cnt = 0;
	int unsigned rx_wait = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	logic hold_rx = 1'b0;

	xoroshiro_bounded_random i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	xoroshiro_bounded_random_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle cycles before one transaction, none while in a burst
	function automatic int unsigned pick_gap(input bit burst);
		if (burst)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// offer one request and wait until it is taken
	task automatic send_req(input logic kind, input logic [30:0] bnd, input logic [31:0] seed);
		int unsigned gap;
		gap = pick_gap(tx_burst);
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, seed, bnd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
	endtask

	// result side ready with per-transaction gaps and a long hold-off
	always @(posedge clk) begin : rx_side
		logic nxt;
		if (m_tvalid && m_tready) begin
			rx_wait = pick_gap(rx_burst);
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
		end
		if (!arst_n || hold_rx) begin
			nxt = 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait = rx_wait - 1;
			nxt = 1'b0;
		end else begin
			nxt = 1'b1;
		end
		m_tready <= nxt;
	end

	// long receiver stall so the block backs up into its input
	initial begin : rx_hold
		wait (n_sent >= HOLD_AFTER);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// cycle counter and watchdog
	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin : watchdog
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("xoroshiro_bounded_random test failed");
		$finish;
	end

	// stimulus and verdict
	initial begin : stim
		logic [31:0] bnd;
		logic [31:0] seed;
		logic kind;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: trivial bounds, extremes, high rejection, reseed corners
		send_req(REQ_DRAW, 31'd0, 32'hFFFF_FFFF);
		send_req(REQ_DRAW, 31'd1, 32'h0);
		send_req(REQ_DRAW, 31'd2, 32'h0);
		send_req(REQ_DRAW, 31'd3, 32'h0);
		send_req(REQ_DRAW, 31'h7FFF_FFFF, 32'h0);
		send_req(REQ_DRAW, 31'h7FFF_FFFE, 32'h0);
		send_req(REQ_DRAW, 31'h4000_0000, 32'h0);
		send_req(REQ_DRAW, 31'h5555_5556, 32'h0);
		send_req(REQ_SEED, 31'h7FFF_FFFF, 32'h0);
		send_req(REQ_DRAW, 31'd10, 32'h0);
		send_req(REQ_DRAW, 31'd1, 32'h0);
		send_req(REQ_SEED, 31'd0, 32'hFFFF_FFFF);
		send_req(REQ_DRAW, 31'h7FFF_FFFF, 32'h0);
		send_req(REQ_SEED, 31'd5, 32'h8000_0000);
		send_req(REQ_DRAW, 31'd2, 32'h0);
		send_req(REQ_SEED, 31'd0, 32'h1);
		send_req(REQ_DRAW, 31'h5555_5555, 32'h0);
		send_req(REQ_DRAW, 31'd1000, 32'h0);
		send_req(REQ_DRAW, 31'd5, 32'h1234_5678);
		send_req(REQ_SEED, 31'h2AAA_AAAA, 32'h3FFF_FFFF);
		send_req(REQ_DRAW, 31'd0, 32'h0);
		send_req(REQ_DRAW, 31'd2, 32'h0);

		// random requests, mostly draws with a spread of bound shapes
		repeat (RANDOM_ITEMS) begin
			kind = ($urandom_range(0, 11) == 0) ? REQ_SEED : REQ_DRAW;
			seed = $urandom();
			case ($urandom_range(0, 9))
				0:       bnd = $urandom_range(0, 1);
				1, 2:    bnd = $urandom_range(2, 17);
				3, 4, 5: bnd = $urandom();
				6:       bnd = (32'd1 << $urandom_range(1, 30)) + $urandom_range(0, 2) - 1;
				7:       bnd = $urandom_range(32'h5555_0000, 32'h5555_FFFF);
				8:       bnd = $urandom_range(32'h7FFF_FF00, 32'h7FFF_FFFF);
				default: bnd = $urandom_range(18, 1000);
			endcase
			send_req(kind, bnd[30:0], seed);
		end
		s_tvalid <= 1'b0;

		// drain the outstanding results
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("xoroshiro_bounded_random test passed");
		else
			$display("xoroshiro_bounded_random test failed");
		$finish;
	end

endmodule
